// ===== rtl/ps2_to_key_matrix_translator_top_defines.svh =====
// Assertion macros for the checker file of the PS/2 to key matrix translator.
// Depends on nothing; included by bare file name.
`ifndef PS2_TO_KEY_MATRIX_TRANSLATOR_TOP_DEFINES_SVH
`define PS2_TO_KEY_MATRIX_TRANSLATOR_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define P2KM_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define P2KM_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/p2km_pkg.sv =====
// Types, key codes and the key map table of the PS/2 to key matrix translator.
// Depends on nothing.
`default_nettype none

package p2km_pkg;

  localparam logic [7:0] PFX_REL   = 8'hF0;
  localparam logic [7:0] PFX_EXT   = 8'hE0;
  localparam logic [7:0] KEY_NONE  = 8'hFF;
  localparam logic [7:0] KEY_CTRL  = 8'h14;
  localparam logic [7:0] KEY_LEFT  = 8'h6B;
  localparam logic [7:0] KEY_RIGHT = 8'h74;
  localparam logic [7:0] KEY_DOWN  = 8'h72;
  localparam logic [7:0] KEY_UP    = 8'h75;
  localparam logic [7:0] KEY_F12   = 8'h07;
  localparam logic [7:0] KEY_F11   = 8'h78;
  localparam logic [7:0] KEY_F10   = 8'h09;
  localparam logic [6:0] SW_MAGIC  = 7'h58;
  localparam logic [6:0] SW_RESET  = 7'h68;
  localparam logic [6:0] SW_PAUSE  = 7'h78;

  // Decoded scan group, registered at acceptance.
  typedef struct packed {
    logic       code_valid;
    logic       press;
    logic       ext;
    logic [7:0] mk;
  } scan_dec_t;

  // Key map entry: up to two switch addresses, KEY_NONE when unused.
  typedef struct packed {
    logic [7:0] k1;
    logic [7:0] k2;
  } kmap_t;

  typedef struct packed {
    logic ctrl;
    logic left;
    logic right;
    logic down;
    logic pause;
  } key_state_t;

  // State after the current group, plus whether its commands are suppressed.
  typedef struct packed {
    key_state_t st;
    logic       swallow;
  } state_upd_t;

  typedef struct packed {
    logic       command_valid;
    logic [6:0] switch_address;
    logic       switch_closed;
    logic       osd_select;
    logic       osd_right;
    logic       osd_left;
    logic       ctrl_active;
    logic       last;
  } result_t;

  function automatic kmap_t kmap_lookup(input logic ext, input logic [7:0] code);
    kmap_t k;
    k = '{k1: KEY_NONE, k2: KEY_NONE};
    if (ext) begin
      case (code)
        8'h75: k = '{8'h00, 8'h34};
        8'h6B: k = '{8'h00, 8'h43};
        8'h72: k = '{8'h00, 8'h44};
        8'h74: k = '{8'h00, 8'h24};
        8'h4A: k = '{8'h17, 8'h40};
        8'h5A: k = '{8'h06, 8'hFF};
        8'h7D: k = '{8'h00, 8'h23};
        8'h7A: k = '{8'h00, 8'h33};
        default: k = '{KEY_NONE, KEY_NONE};
      endcase
    end else begin
      case (code)
        8'h0D: k = '{8'h00, 8'h17};  8'h12: k = '{8'h00, 8'hFF};
        8'h15: k = '{8'h02, 8'hFF};  8'h16: k = '{8'h03, 8'hFF};
        8'h1A: k = '{8'h10, 8'hFF};  8'h1B: k = '{8'h11, 8'hFF};
        8'h1C: k = '{8'h01, 8'hFF};  8'h1D: k = '{8'h12, 8'hFF};
        8'h1E: k = '{8'h13, 8'hFF};  8'h21: k = '{8'h30, 8'hFF};
        8'h22: k = '{8'h20, 8'hFF};  8'h23: k = '{8'h21, 8'hFF};
        8'h24: k = '{8'h22, 8'hFF};  8'h25: k = '{8'h33, 8'hFF};
        8'h26: k = '{8'h23, 8'hFF};  8'h29: k = '{8'h07, 8'hFF};
        8'h2A: k = '{8'h40, 8'hFF};  8'h2B: k = '{8'h31, 8'hFF};
        8'h2C: k = '{8'h42, 8'hFF};  8'h2D: k = '{8'h32, 8'hFF};
        8'h2E: k = '{8'h43, 8'hFF};  8'h31: k = '{8'h37, 8'hFF};
        8'h32: k = '{8'h47, 8'hFF};  8'h33: k = '{8'h46, 8'hFF};
        8'h34: k = '{8'h41, 8'hFF};  8'h35: k = '{8'h45, 8'hFF};
        8'h36: k = '{8'h44, 8'hFF};  8'h3A: k = '{8'h27, 8'hFF};
        8'h3B: k = '{8'h36, 8'hFF};  8'h3C: k = '{8'h35, 8'hFF};
        8'h3D: k = '{8'h34, 8'hFF};  8'h3E: k = '{8'h24, 8'hFF};
        8'h41: k = '{8'h17, 8'h37};  8'h42: k = '{8'h26, 8'hFF};
        8'h43: k = '{8'h25, 8'hFF};  8'h44: k = '{8'h15, 8'hFF};
        8'h45: k = '{8'h04, 8'hFF};  8'h46: k = '{8'h14, 8'hFF};
        8'h49: k = '{8'h17, 8'h27};  8'h4A: k = '{8'h17, 8'h40};
        8'h4B: k = '{8'h16, 8'hFF};  8'h4C: k = '{8'h17, 8'h15};
        8'h4D: k = '{8'h05, 8'hFF};  8'h4E: k = '{8'h17, 8'h36};
        8'h52: k = '{8'h17, 8'h05};  8'h55: k = '{8'h17, 8'h16};
        8'h58: k = '{8'h00, 8'h13};  8'h59: k = '{8'h17, 8'hFF};
        8'h5A: k = '{8'h06, 8'hFF};  8'h66: k = '{8'h00, 8'h04};
        8'h69: k = '{8'h03, 8'hFF};  8'h6B: k = '{8'h33, 8'hFF};
        8'h6C: k = '{8'h34, 8'hFF};  8'h70: k = '{8'h04, 8'hFF};
        8'h71: k = '{8'h17, 8'h27};  8'h72: k = '{8'h13, 8'hFF};
        8'h73: k = '{8'h43, 8'hFF};  8'h74: k = '{8'h44, 8'hFF};
        8'h75: k = '{8'h24, 8'hFF};  8'h76: k = '{8'h00, 8'h03};
        8'h79: k = '{8'h17, 8'h26};  8'h7A: k = '{8'h23, 8'hFF};
        8'h7B: k = '{8'h17, 8'h36};  8'h7C: k = '{8'h17, 8'h47};
        8'h7D: k = '{8'h14, 8'hFF};
        default: k = '{KEY_NONE, KEY_NONE};
      endcase
    end
    return k;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/p2km_scan_if.sv =====
// Handshake channel carrying one raw PS/2 scan code group per word.
// Depends on nothing.
`default_nettype none

interface p2km_scan_if;
  logic       valid;
  logic       ready;
  logic [1:0] code_count;
  logic [7:0] first_byte;
  logic [7:0] second_byte;
  logic [7:0] third_byte;

  modport source (output valid, code_count, first_byte, second_byte, third_byte,
                  input ready);
  modport sink   (input valid, code_count, first_byte, second_byte, third_byte,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/p2km_cmd_if.sv =====
// Handshake channel carrying one matrix switch result per word.
// Depends on nothing.
`default_nettype none

interface p2km_cmd_if;
  logic       valid;
  logic       ready;
  logic       command_valid;
  logic [6:0] switch_address;
  logic       switch_closed;
  logic       osd_select;
  logic       osd_right;
  logic       osd_left;
  logic       ctrl_active;
  logic       last;

  modport source (output valid, command_valid, switch_address, switch_closed,
                  osd_select, osd_right, osd_left, ctrl_active, last,
                  input ready);
  modport sink   (input valid, command_valid, switch_address, switch_closed,
                  osd_select, osd_right, osd_left, ctrl_active, last,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/p2km_rom.sv =====
// Synchronous key map ROM: one registered lookup per accepted scan group.
// Depends on p2km_pkg.
`default_nettype none

module p2km_rom (
  input  wire logic            clk,
  input  wire logic            en,
  input  wire logic            ext,
  input  wire logic [7:0]      code,
  output p2km_pkg::kmap_t      entry
);

  always_ff @(posedge clk) begin
    if (en) begin
      entry <= p2km_pkg::kmap_lookup(ext, code);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/p2km_state.sv =====
// Key state memory with read, update and write back, forwarding the last write.
// Depends on p2km_pkg.
`default_nettype none

module p2km_state (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  rd_en,
  input  wire logic                  wr_en,
  input  wire p2km_pkg::scan_dec_t   dec,
  output p2km_pkg::state_upd_t       upd
);

  p2km_pkg::key_state_t st_mem [1];
  logic                 st_written;
  p2km_pkg::key_state_t rd_q;
  logic                 rd_written;
  logic                 fwd;
  p2km_pkg::key_state_t wr_q;
  p2km_pkg::key_state_t cur;
  p2km_pkg::key_state_t nxt;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      st_mem[0] <= nxt;
    end
    if (rd_en) begin
      rd_q <= st_mem[0];
      wr_q <= nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st_written <= 1'b0;
      rd_written <= 1'b0;
      fwd        <= 1'b0;
    end else begin
      if (wr_en) begin
        st_written <= 1'b1;
      end
      if (rd_en) begin
        rd_written <= st_written;
        fwd        <= wr_en;
      end
    end
  end

  // A write in the same cycle as the read is not yet in rd_q.
  always_comb begin
    if (fwd) begin
      cur = wr_q;
    end else if (rd_written) begin
      cur = rd_q;
    end else begin
      cur = '0;
    end
  end

  always_comb begin
    logic sw;
    nxt = cur;
    if (dec.code_valid) begin
      if (dec.mk == p2km_pkg::KEY_CTRL)  nxt.ctrl  = dec.press;
      if (dec.mk == p2km_pkg::KEY_LEFT)  nxt.left  = dec.press;
      if (dec.mk == p2km_pkg::KEY_RIGHT) nxt.right = dec.press;
      if (dec.mk == p2km_pkg::KEY_DOWN)  nxt.down  = dec.press;
      if (dec.mk == p2km_pkg::KEY_UP) begin
        nxt.left  = dec.press;
        nxt.right = dec.press;
      end
    end
    sw = !dec.code_valid || (nxt.ctrl && dec.press);
    if (!sw && dec.press && (dec.mk == p2km_pkg::KEY_F10)) begin
      nxt.pause = !nxt.pause;
    end
    upd.st      = nxt;
    upd.swallow = sw;
  end

endmodule

`default_nettype wire

// ===== rtl/p2km_out.sv =====
// Result queue: takes one or two results per cycle, hands out one per word.
// Depends on p2km_pkg.
`default_nettype none

module p2km_out #(
  parameter int DEPTH = 4
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire logic              push_two,
  input  wire p2km_pkg::result_t res0,
  input  wire p2km_pkg::result_t res1,
  output logic                   room,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output p2km_pkg::result_t      out_data
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);

  p2km_pkg::result_t q [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic [PW-1:0] wr_ptr1;
  logic [PW-1:0] wr_ptr2;
  logic          pop;
  logic [CW-1:0] count_next;

  assign wr_ptr1   = (wr_ptr == LAST_IDX) ? '0 : wr_ptr + 1'b1;
  assign wr_ptr2   = (wr_ptr1 == LAST_IDX) ? '0 : wr_ptr1 + 1'b1;
  assign room      = (count <= CW'(DEPTH - 2));
  assign out_valid = (count != '0);
  assign out_data  = q[rd_ptr];
  assign pop       = out_valid && out_ready;

  always_comb begin
    count_next = count;
    if (push) begin
      count_next = count_next + (push_two ? CW'(2) : CW'(1));
    end
    if (pop) begin
      count_next = count_next - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= res0;
      if (push_two) begin
        q[wr_ptr1] <= res1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= push_two ? wr_ptr2 : wr_ptr1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_IDX) ? '0 : rd_ptr + 1'b1;
      end
      count <= count_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ps2_to_key_matrix_translator_top.sv =====
// Top level of the PS/2 set-2 to key matrix switch translator.
// Depends on p2km_pkg, p2km_scan_if, p2km_cmd_if, p2km_rom, p2km_state, p2km_out.
//
//   channel  direction  word
//   scan     in         one raw scan code group (count and up to three bytes)
//   cmd      out        one switch command or status result, last marks the end
//
// An accepted group waits in the lookup stage until the result queue has room, then
// leaves as one or two result words; a new group is taken every cycle the result queue
// has room for two words. Sustained rate is set by the single result word per cycle
// on cmd. Reset clears the key state at once (a written flag marks the state memory)
// and empties the queue. A stalled cmd fills the queue and then holds off scan.
`default_nettype none

module ps2_to_key_matrix_translator_top #(
  parameter int FIFO_DEPTH = 4
) (
  input  wire logic      clk,
  input  wire logic      rst,
  p2km_scan_if.sink      scan,
  p2km_cmd_if.source     cmd
);

  // Decode of the incoming group: make code, release prefix and extended prefix.
  p2km_pkg::scan_dec_t dec_in;
  logic [7:0]          status_byte;
  logic                accept;

  always_comb begin
    case (scan.code_count)
      2'd1:    dec_in.mk = scan.first_byte;
      2'd2:    dec_in.mk = scan.second_byte;
      default: dec_in.mk = scan.third_byte;
    endcase
    status_byte       = (scan.code_count == 2'd3) ? scan.second_byte : scan.first_byte;
    dec_in.code_valid = (scan.code_count != 2'd0);
    dec_in.press      = (status_byte != p2km_pkg::PFX_REL);
    dec_in.ext        = (scan.first_byte == p2km_pkg::PFX_EXT);
  end

  // Lookup stage: the decoded group waits here while the ROM and state memory
  // deliver their registered read data.
  logic                 s1_valid;
  p2km_pkg::scan_dec_t  dec_q;
  logic                 s1_adv;
  logic                 room;
  p2km_pkg::kmap_t      kmap;
  p2km_pkg::state_upd_t upd;

  // No word is taken while reset is high.
  assign s1_adv     = s1_valid && room;
  assign scan.ready = !rst && (!s1_valid || s1_adv);
  assign accept     = scan.valid && scan.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (scan.ready) begin
      s1_valid <= scan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      dec_q <= dec_in;
    end
  end

  p2km_rom u_rom (
    .clk   (clk),
    .en    (accept),
    .ext   (dec_in.ext),
    .code  (dec_in.mk),
    .entry (kmap)
  );

  // The state is written back when the group leaves the lookup stage; the read
  // for the next group happens in that same cycle and is forwarded inside.
  p2km_state u_state (
    .clk   (clk),
    .rst   (rst),
    .rd_en (accept),
    .wr_en (s1_adv),
    .dec   (dec_q),
    .upd   (upd)
  );

  // Up to three candidate commands in order: the two map entries, then the
  // function key. Only the first two valid ones are sent.
  logic       c0_v, c1_v, c2_v;
  logic [6:0] c2_addr;
  logic       c2_val;
  logic       r0_v, r1_v;
  logic [6:0] r0_addr, r1_addr;
  logic       r0_val, r1_val;

  always_comb begin
    c0_v    = !upd.swallow && (kmap.k1 != p2km_pkg::KEY_NONE);
    c1_v    = !upd.swallow && (kmap.k2 != p2km_pkg::KEY_NONE);
    c2_v    = 1'b0;
    c2_addr = '0;
    c2_val  = 1'b0;
    if (!upd.swallow) begin
      case (dec_q.mk)
        p2km_pkg::KEY_F12: begin
          c2_v    = 1'b1;
          c2_addr = p2km_pkg::SW_RESET;
          c2_val  = dec_q.press;
        end
        p2km_pkg::KEY_F11: begin
          c2_v    = 1'b1;
          c2_addr = p2km_pkg::SW_MAGIC;
          c2_val  = dec_q.press;
        end
        p2km_pkg::KEY_F10: begin
          c2_v    = 1'b1;
          c2_addr = p2km_pkg::SW_PAUSE;
          c2_val  = upd.st.pause;
        end
        default: begin
          c2_v = 1'b0;
        end
      endcase
    end

    if (c0_v) begin
      r0_v = 1'b1;  r0_addr = kmap.k1[6:0]; r0_val = dec_q.press;
      r1_v = c1_v || c2_v;
      r1_addr = c1_v ? kmap.k2[6:0] : c2_addr;
      r1_val  = c1_v ? dec_q.press : c2_val;
    end else if (c1_v) begin
      r0_v = 1'b1;  r0_addr = kmap.k2[6:0]; r0_val = dec_q.press;
      r1_v = c2_v;  r1_addr = c2_addr;      r1_val = c2_val;
    end else begin
      r0_v = c2_v;  r0_addr = c2_addr;      r0_val = c2_val;
      r1_v = 1'b0;  r1_addr = '0;           r1_val = 1'b0;
    end
  end

  // A group with no command still yields one word carrying the status bits.
  p2km_pkg::result_t res0, res1, res_base;

  always_comb begin
    res_base                = '0;
    res_base.osd_select     = upd.st.ctrl && upd.st.down;
    res_base.osd_right      = upd.st.ctrl && upd.st.right;
    res_base.osd_left       = upd.st.ctrl && upd.st.left;
    res_base.ctrl_active    = upd.st.ctrl;

    res0                = res_base;
    res0.command_valid  = r0_v;
    res0.switch_address = r0_v ? r0_addr : '0;
    res0.switch_closed  = r0_v && r0_val;
    res0.last           = !r1_v;

    res1                = res_base;
    res1.command_valid  = 1'b1;
    res1.switch_address = r1_addr;
    res1.switch_closed  = r1_val;
    res1.last           = 1'b1;
  end

  p2km_pkg::result_t out_data;

  p2km_out #(
    .DEPTH (FIFO_DEPTH)
  ) u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (s1_adv),
    .push_two  (r1_v),
    .res0      (res0),
    .res1      (res1),
    .room      (room),
    .out_valid (cmd.valid),
    .out_ready (cmd.ready),
    .out_data  (out_data)
  );

  assign cmd.command_valid  = out_data.command_valid;
  assign cmd.switch_address = out_data.switch_address;
  assign cmd.switch_closed  = out_data.switch_closed;
  assign cmd.osd_select     = out_data.osd_select;
  assign cmd.osd_right      = out_data.osd_right;
  assign cmd.osd_left       = out_data.osd_left;
  assign cmd.ctrl_active    = out_data.ctrl_active;
  assign cmd.last           = out_data.last;

endmodule

`default_nettype wire

// ===== rtl/p2km_checker.sv =====
// Port-level checks on the translator's result channel, bound to the top level.
// Depends on ps2_to_key_matrix_translator_top_defines.svh.
`default_nettype none

`include "ps2_to_key_matrix_translator_top_defines.svh"

module p2km_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       cmd_valid,
  input wire logic       cmd_ready,
  input wire logic       command_valid,
  input wire logic [6:0] switch_address,
  input wire logic       switch_closed,
  input wire logic       osd_select,
  input wire logic       osd_right,
  input wire logic       osd_left,
  input wire logic       ctrl_active,
  input wire logic       last
);

  logic [13:0] payload;

  assign payload = {command_valid, switch_address, switch_closed, osd_select,
                    osd_right, osd_left, ctrl_active, last};

  `P2KM_ASSERT_NXT(a_hold, clk, rst, cmd_valid && !cmd_ready, cmd_valid && $stable(payload), "stalled result word changed")
  `P2KM_ASSERT_NXT(a_pair, clk, rst, cmd_valid && cmd_ready && !last, cmd_valid, "second result word did not follow at once")
  `P2KM_ASSERT_IMP(a_empty, clk, rst, cmd_valid && !command_valid, last && (switch_address == 7'd0) && !switch_closed, "word without command is not a lone cleared word")
  `P2KM_ASSERT_IMP(a_osd, clk, rst, cmd_valid && (osd_select || osd_right || osd_left), ctrl_active, "overlay button without Ctrl")

endmodule

bind ps2_to_key_matrix_translator_top p2km_checker u_p2km_checker (
  .clk            (clk),
  .rst            (rst),
  .cmd_valid      (cmd.valid),
  .cmd_ready      (cmd.ready),
  .command_valid  (cmd.command_valid),
  .switch_address (cmd.switch_address),
  .switch_closed  (cmd.switch_closed),
  .osd_select     (cmd.osd_select),
  .osd_right      (cmd.osd_right),
  .osd_left       (cmd.osd_left),
  .ctrl_active    (cmd.ctrl_active),
  .last           (cmd.last)
);

`default_nettype wire

// ===== tb/p2km_switch_checker.sv =====
// Checker for the PS/2 to key matrix translator: watches both channels,
// predicts the switch words of every accepted scan group and compares them.
// Depends on p2km_pkg, p2km_scan_if and p2km_cmd_if.

module p2km_switch_checker (
  input  logic clk,
  input  logic rst,
  p2km_scan_if scan,
  p2km_cmd_if  cmd,
  output int   mismatches,
  output int   pending,
  output int   words_checked
);

  p2km_pkg::result_t    expected_words [$];
  p2km_pkg::result_t    oldest;
  p2km_pkg::key_state_t held;
  int                   fail_count = 0;
  int                   checked = 0;
  int                   pending_count = 0;

  assign mismatches    = fail_count;
  assign pending       = pending_count;
  assign words_checked = checked;

  task automatic compare_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  // Updates the held keys for one group and queues the words it should produce.
  task automatic predict_switch_words(input logic [1:0] count, input logic [7:0] b0,
                                      input logic [7:0] b1, input logic [7:0] b2);
    logic [7:0] key_code;
    logic [7:0] status;
    logic       pressed;
    logic [7:0] first_sw;
    logic [7:0] second_sw;
    logic [6:0] sw_addr [0:1];
    logic       sw_closed [0:1];
    int         n_cmds;
    int         n_words;
    p2km_pkg::result_t w;
    n_cmds = 0;
    if (count != 2'd0) begin
      key_code = (count == 2'd1) ? b0 : (count == 2'd2) ? b1 : b2;
      status   = (count == 2'd3) ? b1 : b0;
      pressed  = (status != p2km_pkg::PFX_REL);
      if (key_code == p2km_pkg::KEY_CTRL)  held.ctrl  = pressed;
      if (key_code == p2km_pkg::KEY_LEFT)  held.left  = pressed;
      if (key_code == p2km_pkg::KEY_RIGHT) held.right = pressed;
      if (key_code == p2km_pkg::KEY_DOWN)  held.down  = pressed;
      if (key_code == p2km_pkg::KEY_UP) begin
        held.left  = pressed;
        held.right = pressed;
      end
      // Presses are swallowed while Ctrl is down; releases always go out.
      if (!(held.ctrl && pressed)) begin
        first_sw  = p2km_pkg::KEY_NONE;
        second_sw = p2km_pkg::KEY_NONE;
        if (b0 == p2km_pkg::PFX_EXT) begin
          case (key_code)
            8'h75: {first_sw, second_sw} = 16'h0034;
            8'h6B: {first_sw, second_sw} = 16'h0043;
            8'h72: {first_sw, second_sw} = 16'h0044;
            8'h74: {first_sw, second_sw} = 16'h0024;
            8'h4A: {first_sw, second_sw} = 16'h1740;
            8'h5A: {first_sw, second_sw} = 16'h06FF;
            8'h7D: {first_sw, second_sw} = 16'h0023;
            8'h7A: {first_sw, second_sw} = 16'h0033;
            default: ;
          endcase
        end else begin
          case (key_code)
            8'h0D: {first_sw, second_sw} = 16'h0017; 8'h12: {first_sw, second_sw} = 16'h00FF;
            8'h15: {first_sw, second_sw} = 16'h02FF; 8'h16: {first_sw, second_sw} = 16'h03FF;
            8'h1A: {first_sw, second_sw} = 16'h10FF; 8'h1B: {first_sw, second_sw} = 16'h11FF;
            8'h1C: {first_sw, second_sw} = 16'h01FF; 8'h1D: {first_sw, second_sw} = 16'h12FF;
            8'h1E: {first_sw, second_sw} = 16'h13FF; 8'h21: {first_sw, second_sw} = 16'h30FF;
            8'h22: {first_sw, second_sw} = 16'h20FF; 8'h23: {first_sw, second_sw} = 16'h21FF;
            8'h24: {first_sw, second_sw} = 16'h22FF; 8'h25: {first_sw, second_sw} = 16'h33FF;
            8'h26: {first_sw, second_sw} = 16'h23FF; 8'h29: {first_sw, second_sw} = 16'h07FF;
            8'h2A: {first_sw, second_sw} = 16'h40FF; 8'h2B: {first_sw, second_sw} = 16'h31FF;
            8'h2C: {first_sw, second_sw} = 16'h42FF; 8'h2D: {first_sw, second_sw} = 16'h32FF;
            8'h2E: {first_sw, second_sw} = 16'h43FF; 8'h31: {first_sw, second_sw} = 16'h37FF;
            8'h32: {first_sw, second_sw} = 16'h47FF; 8'h33: {first_sw, second_sw} = 16'h46FF;
            8'h34: {first_sw, second_sw} = 16'h41FF; 8'h35: {first_sw, second_sw} = 16'h45FF;
            8'h36: {first_sw, second_sw} = 16'h44FF; 8'h3A: {first_sw, second_sw} = 16'h27FF;
            8'h3B: {first_sw, second_sw} = 16'h36FF; 8'h3C: {first_sw, second_sw} = 16'h35FF;
            8'h3D: {first_sw, second_sw} = 16'h34FF; 8'h3E: {first_sw, second_sw} = 16'h24FF;
            8'h41: {first_sw, second_sw} = 16'h1737; 8'h42: {first_sw, second_sw} = 16'h26FF;
            8'h43: {first_sw, second_sw} = 16'h25FF; 8'h44: {first_sw, second_sw} = 16'h15FF;
            8'h45: {first_sw, second_sw} = 16'h04FF; 8'h46: {first_sw, second_sw} = 16'h14FF;
            8'h49: {first_sw, second_sw} = 16'h1727; 8'h4A: {first_sw, second_sw} = 16'h1740;
            8'h4B: {first_sw, second_sw} = 16'h16FF; 8'h4C: {first_sw, second_sw} = 16'h1715;
            8'h4D: {first_sw, second_sw} = 16'h05FF; 8'h4E: {first_sw, second_sw} = 16'h1736;
            8'h52: {first_sw, second_sw} = 16'h1705; 8'h55: {first_sw, second_sw} = 16'h1716;
            8'h58: {first_sw, second_sw} = 16'h0013; 8'h59: {first_sw, second_sw} = 16'h17FF;
            8'h5A: {first_sw, second_sw} = 16'h06FF; 8'h66: {first_sw, second_sw} = 16'h0004;
            8'h69: {first_sw, second_sw} = 16'h03FF; 8'h6B: {first_sw, second_sw} = 16'h33FF;
            8'h6C: {first_sw, second_sw} = 16'h34FF; 8'h70: {first_sw, second_sw} = 16'h04FF;
            8'h71: {first_sw, second_sw} = 16'h1727; 8'h72: {first_sw, second_sw} = 16'h13FF;
            8'h73: {first_sw, second_sw} = 16'h43FF; 8'h74: {first_sw, second_sw} = 16'h44FF;
            8'h75: {first_sw, second_sw} = 16'h24FF; 8'h76: {first_sw, second_sw} = 16'h0003;
            8'h79: {first_sw, second_sw} = 16'h1726; 8'h7A: {first_sw, second_sw} = 16'h23FF;
            8'h7B: {first_sw, second_sw} = 16'h1736; 8'h7C: {first_sw, second_sw} = 16'h1747;
            8'h7D: {first_sw, second_sw} = 16'h14FF;
            default: ;
          endcase
        end
        if (first_sw != p2km_pkg::KEY_NONE) begin
          sw_addr[n_cmds]   = first_sw[6:0];
          sw_closed[n_cmds] = pressed;
          n_cmds++;
        end
        if (second_sw != p2km_pkg::KEY_NONE && n_cmds < 2) begin
          sw_addr[n_cmds]   = second_sw[6:0];
          sw_closed[n_cmds] = pressed;
          n_cmds++;
        end
        if (key_code == p2km_pkg::KEY_F12 && n_cmds < 2) begin
          sw_addr[n_cmds]   = p2km_pkg::SW_RESET;
          sw_closed[n_cmds] = pressed;
          n_cmds++;
        end
        if (key_code == p2km_pkg::KEY_F11 && n_cmds < 2) begin
          sw_addr[n_cmds]   = p2km_pkg::SW_MAGIC;
          sw_closed[n_cmds] = pressed;
          n_cmds++;
        end
        if (key_code == p2km_pkg::KEY_F10) begin
          if (pressed) held.pause = !held.pause;
          if (n_cmds < 2) begin
            sw_addr[n_cmds]   = p2km_pkg::SW_PAUSE;
            sw_closed[n_cmds] = held.pause;
            n_cmds++;
          end
        end
      end
    end
    // A group with no command still yields one status word.
    n_words = (n_cmds == 0) ? 1 : n_cmds;
    for (int k = 0; k < n_words; k++) begin
      w.command_valid  = (n_cmds != 0);
      w.switch_address = (n_cmds != 0) ? sw_addr[k] : 7'd0;
      w.switch_closed  = (n_cmds != 0) ? sw_closed[k] : 1'b0;
      w.osd_select     = held.ctrl & held.down;
      w.osd_right      = held.ctrl & held.right;
      w.osd_left       = held.ctrl & held.left;
      w.ctrl_active    = held.ctrl;
      w.last           = (k == n_words - 1);
      expected_words.push_back(w);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      held = '0;
      expected_words.delete();
    end else begin
      if (scan.valid && scan.ready) begin
        predict_switch_words(scan.code_count, scan.first_byte, scan.second_byte,
                             scan.third_byte);
      end
      if (cmd.valid && cmd.ready) begin
        checked++;
        if (expected_words.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected word, expected none, actual address %0h closed %0b",
                   $time, cmd.switch_address, cmd.switch_closed);
        end else begin
          oldest = expected_words.pop_front();
          compare_field("command_valid",  oldest.command_valid,  cmd.command_valid);
          compare_field("switch_address", oldest.switch_address, cmd.switch_address);
          compare_field("switch_closed",  oldest.switch_closed,  cmd.switch_closed);
          compare_field("osd_select",     oldest.osd_select,     cmd.osd_select);
          compare_field("osd_right",      oldest.osd_right,      cmd.osd_right);
          compare_field("osd_left",       oldest.osd_left,       cmd.osd_left);
          compare_field("ctrl_active",    oldest.ctrl_active,    cmd.ctrl_active);
          compare_field("last",           oldest.last,           cmd.last);
        end
      end
    end
    pending_count = expected_words.size();
  end

endmodule

// ===== tb/tb_ps2_to_key_matrix_translator_top.sv =====
// Top of the PS/2 to key matrix translator testbench: clock, reset, scan group
// stimulus, result word back-pressure and the verdict.
// Depends on p2km_pkg, both channel interfaces, the block and p2km_switch_checker.

module tb_ps2_to_key_matrix_translator_top;

  // A few ordinary keys used by the directed part.
  localparam logic [7:0] KEY_A    = 8'h1C;
  localparam logic [7:0] KEY_TAB  = 8'h0D;
  localparam logic [7:0] KEY_BKSP = 8'h66;
  localparam logic [7:0] KEY_ESC  = 8'h76;

  // Keys the random part favors: every held key, every special key and four
  // map entries, three of which yield two switch commands.
  localparam int HOT_COUNT = 12;
  localparam logic [7:0] HOT_KEYS [HOT_COUNT] = '{
    p2km_pkg::KEY_CTRL, p2km_pkg::KEY_LEFT, p2km_pkg::KEY_RIGHT, p2km_pkg::KEY_DOWN,
    p2km_pkg::KEY_UP, p2km_pkg::KEY_F12, p2km_pkg::KEY_F11, p2km_pkg::KEY_F10,
    KEY_TAB, KEY_BKSP, KEY_ESC, KEY_A
  };

  // Length of the receiver hold-off, long enough to fill the result queue
  // several times over and stall the scan channel.
  localparam int LONG_HOLD = 200;

  logic clk;
  logic rst;

  // Shared knobs: no_idle turns off the random gaps on both sides, and
  // hold_request asks the receiver for one long hold-off.
  bit no_idle      = 1'b0;
  bit hold_request = 1'b0;
  int groups_sent  = 0;

  int mismatches;
  int pending;
  int words_checked;

  p2km_scan_if scan_ch ();
  p2km_cmd_if  cmd_ch ();

  ps2_to_key_matrix_translator_top DUT (
    .clk  (clk),
    .rst  (rst),
    .scan (scan_ch),
    .cmd  (cmd_ch)
  );

  p2km_switch_checker checker_inst (
    .clk           (clk),
    .rst           (rst),
    .scan          (scan_ch),
    .cmd           (cmd_ch),
    .mismatches    (mismatches),
    .pending       (pending),
    .words_checked (words_checked)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Offers one scan group after a random gap and returns at the edge where it is
  // accepted. Valid stays high into the next group when no gap is drawn, so valid
  // never gets two assignments in one step.
  task automatic send_group(input logic [1:0] count, input logic [7:0] b0,
                            input logic [7:0] b1, input logic [7:0] b2);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      scan_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    scan_ch.valid       <= 1'b1;
    scan_ch.code_count  <= count;
    scan_ch.first_byte  <= b0;
    scan_ch.second_byte <= b1;
    scan_ch.third_byte  <= b2;
    do @(posedge clk); while (!scan_ch.ready);
    groups_sent++;
  endtask

  // Most groups are well-formed make or break codes, with or without the E0
  // prefix, on a favored or a random key. The rest is noise with any count,
  // including zero. Bytes that the group does not use are random as well.
  task automatic send_random_group(input bit noisy);
    logic [7:0] code;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [1:0] count;
    bit         ext;
    bit         rel;
    b0    = 8'($urandom);
    b1    = 8'($urandom);
    b2    = 8'($urandom);
    count = 2'($urandom_range(0, 3));
    if (!noisy) begin
      code = ($urandom_range(0, 1) == 0) ? HOT_KEYS[$urandom_range(0, HOT_COUNT - 1)]
                                         : 8'($urandom);
      ext  = ($urandom_range(0, 3) == 0);
      rel  = ($urandom_range(0, 9) < 4);
      case ({ext, rel})
        2'b00: begin
          count = 2'd1;
          b0    = code;
        end
        2'b10: begin
          count = 2'd2;
          b0    = p2km_pkg::PFX_EXT;
          b1    = code;
        end
        2'b01: begin
          count = 2'd2;
          b0    = p2km_pkg::PFX_REL;
          b1    = code;
        end
        default: begin
          count = 2'd3;
          b0    = p2km_pkg::PFX_EXT;
          b1    = p2km_pkg::PFX_REL;
          b2    = code;
        end
      endcase
    end
    send_group(count, b0, b1, b2);
  endtask

  task automatic run_random(input int n_groups);
    repeat (n_groups) send_random_group($urandom_range(0, 99) < 15);
  endtask

  // Withdraws the scan channel and waits until every predicted word has arrived.
  // It waits on a clock edge first so the checker has queued the last accepted group.
  task automatic drain_results();
    scan_ch.valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
  endtask

  // Receiver: a random stall before each word, or one long hold-off when asked.
  initial begin : receiver
    int stall;
    cmd_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        cmd_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        stall = no_idle ? 0 : $urandom_range(0, 6);
        if (stall != 0) begin
          cmd_ch.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      cmd_ch.ready <= 1'b1;
      do @(posedge clk); while (!cmd_ch.valid);
    end
  end

  initial begin
    rst                 <= 1'b1;
    scan_ch.valid       <= 1'b0;
    scan_ch.code_count  <= 2'd0;
    scan_ch.first_byte  <= 8'h00;
    scan_ch.second_byte <= 8'h00;
    scan_ch.third_byte  <= 8'h00;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Plain keys with one and two commands, pressed and released.
    send_group(2'd1, KEY_A, 8'h00, 8'h00);
    send_group(2'd2, p2km_pkg::PFX_REL, KEY_A, 8'h00);
    send_group(2'd1, KEY_TAB, 8'hFF, 8'hFF);
    send_group(2'd2, p2km_pkg::PFX_REL, KEY_TAB, 8'hFF);
    // Extended keys, including a three byte group whose middle byte is not F0.
    send_group(2'd2, p2km_pkg::PFX_EXT, p2km_pkg::KEY_UP, 8'h00);
    send_group(2'd3, p2km_pkg::PFX_EXT, p2km_pkg::PFX_REL, p2km_pkg::KEY_UP);
    send_group(2'd3, p2km_pkg::PFX_EXT, 8'h12, 8'h7D);
    // Lone prefix bytes, an empty group and the byte extremes.
    send_group(2'd1, p2km_pkg::PFX_EXT, 8'h00, 8'h00);
    send_group(2'd1, p2km_pkg::PFX_REL, 8'h00, 8'h00);
    send_group(2'd0, 8'hFF, 8'hFF, 8'hFF);
    send_group(2'd1, 8'h00, 8'h00, 8'h00);
    send_group(2'd3, 8'hFF, 8'hFF, 8'hFF);
    // With Ctrl down, the arrow keys raise the overlay buttons and presses are
    // swallowed, F10 included, so pause must not toggle. Releases still go out.
    send_group(2'd1, p2km_pkg::KEY_CTRL, 8'h00, 8'h00);
    send_group(2'd1, p2km_pkg::KEY_LEFT, 8'h00, 8'h00);
    send_group(2'd2, p2km_pkg::PFX_EXT, p2km_pkg::KEY_RIGHT, 8'h00);
    send_group(2'd1, p2km_pkg::KEY_DOWN, 8'h00, 8'h00);
    send_group(2'd1, p2km_pkg::KEY_F10, 8'h00, 8'h00);
    send_group(2'd2, p2km_pkg::PFX_REL, p2km_pkg::KEY_LEFT, 8'h00);
    send_group(2'd2, p2km_pkg::PFX_REL, p2km_pkg::KEY_UP, 8'h00);
    // The right Ctrl release carries the E0 prefix and still clears Ctrl.
    send_group(2'd3, p2km_pkg::PFX_EXT, p2km_pkg::PFX_REL, p2km_pkg::KEY_CTRL);
    send_group(2'd2, p2km_pkg::PFX_REL, p2km_pkg::KEY_DOWN, 8'h00);
    // Reset and magic switches follow their keys; F10 toggles pause on each press.
    send_group(2'd1, p2km_pkg::KEY_F12, 8'h00, 8'h00);
    send_group(2'd2, p2km_pkg::PFX_REL, p2km_pkg::KEY_F12, 8'h00);
    send_group(2'd2, p2km_pkg::PFX_EXT, p2km_pkg::KEY_F11, 8'h00);
    send_group(2'd2, p2km_pkg::PFX_REL, p2km_pkg::KEY_F11, 8'h00);
    send_group(2'd1, p2km_pkg::KEY_F10, 8'h00, 8'h00);
    send_group(2'd1, p2km_pkg::KEY_F10, 8'h00, 8'h00);
    send_group(2'd2, p2km_pkg::PFX_REL, p2km_pkg::KEY_F10, 8'h00);
    drain_results();

    // Random traffic with idling on both sides.
    run_random(500);
    drain_results();

    // The receiver holds off while the sender keeps offering groups, so the
    // result queue fills and the scan channel stalls.
    hold_request = 1'b1;
    run_random(400);
    drain_results();

    // A stretch with no idling at all, at the block's full rate.
    no_idle = 1'b1;
    run_random(200);
    drain_results();
    no_idle = 1'b0;

    // A second hold-off near the end, then the last random groups.
    hold_request = 1'b1;
    run_random(250);
    drain_results();

    repeat (8) @(posedge clk);
    $display("Covered %0d scan groups and %0d result words: directed keys, random make",
             groups_sent, words_checked);
    $display("and break sequences with noise, two receiver hold-offs and full-rate traffic.");
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

endmodule
